/* hdl/asm_pkg.sv */
// ----------------------------------------------------------------------------
// asm_pkg - shared types for the AABB slide move block
// Coordinate types, collider and probe box structs, command and outcome
// codes, and the box bound and overlap functions used by the control and cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package asm_pkg;

  localparam int MAX_BOXES      = 64;
  localparam int COORD_BITS     = 32;
  localparam int WIDE_BITS      = COORD_BITS + 2;
  localparam int PROBES         = 4;
  localparam int DIM_BITS       = 31;
  localparam int COUNT_BITS     = 7;
  localparam int INDEX_BITS     = 6;
  localparam int CMD_BITS       = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int OUTCOME_BITS   = 3;

  localparam logic [DIM_BITS-1:0]   RADIUS_RESET = DIM_BITS'(32768);
  localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = DIM_BITS'(117965);
  localparam logic [COUNT_BITS-1:0] COUNT_RESET  = '0;

  // probe slots tested in parallel for one item
  localparam int PRB_FULL = 0;
  localparam int PRB_X    = 1;
  localparam int PRB_XZ   = 2;
  localparam int PRB_Z    = 3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_MOVE  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_RADIUS = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_COUNT  = 2'd2
  } reg_t;

  typedef enum logic [OUTCOME_BITS-1:0] {
    OUTC_FULL    = 3'd0,
    OUTC_XZ      = 3'd1,
    OUTC_X       = 3'd2,
    OUTC_Z       = 3'd3,
    OUTC_BLOCKED = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT
  } state_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    wide_t lo_x;
    wide_t hi_x;
    wide_t lo_y;
    wide_t hi_y;
    wide_t lo_z;
    wide_t hi_z;
  } bounds_t;

  typedef struct packed {
    logic              token;
    logic [PROBES-1:0] blocked;
  } chain_t;

  typedef struct packed {
    logic                  load_we;
    logic                  launch;
    logic [COUNT_BITS-1:0] box_count;
  } scan_ctl_t;

  // player box at a point: x and z +/- radius, y up by height
  function automatic bounds_t make_bounds(coord_t px, coord_t py, coord_t pz,
                                         logic [DIM_BITS-1:0] r,
                                         logic [DIM_BITS-1:0] h);
    wide_t   rw;
    wide_t   hw;
    bounds_t b;
    rw     = WIDE_BITS'(signed'({1'b0, r}));
    hw     = WIDE_BITS'(signed'({1'b0, h}));
    b.lo_x = WIDE_BITS'(px) - rw;
    b.hi_x = WIDE_BITS'(px) + rw;
    b.lo_y = WIDE_BITS'(py);
    b.hi_y = WIDE_BITS'(py) + hw;
    b.lo_z = WIDE_BITS'(pz) - rw;
    b.hi_z = WIDE_BITS'(pz) + rw;
    return b;
  endfunction

  // touching faces count as overlap
  function automatic logic overlaps(bounds_t p, box_t b);
    return (p.hi_x >= WIDE_BITS'(b.min_x)) && (p.lo_x <= WIDE_BITS'(b.max_x)) &&
           (p.hi_y >= WIDE_BITS'(b.min_y)) && (p.lo_y <= WIDE_BITS'(b.max_y)) &&
           (p.hi_z >= WIDE_BITS'(b.min_z)) && (p.lo_z <= WIDE_BITS'(b.max_z));
  endfunction

endpackage

`default_nettype wire

/* hdl/asm_cell.sv */
// ----------------------------------------------------------------------------
// asm_cell - one collider box of the cell row
// Holds one box and, as the scan token passes, ORs its overlap with each
// probe box into the blocked flags handed to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module asm_cell import asm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  logic    in_use,
  input  box_t    wr_box,
  input  bounds_t probe [PROBES],
  input  chain_t  link_in,
  output chain_t  link_out
);

  box_t              box;
  logic [PROBES-1:0] hit_here;

  always_ff @(posedge clk) begin
    if (wr) begin
      box <= wr_box;
    end
  end

  always_comb begin
    for (int p = 0; p < PROBES; p++) begin
      hit_here[p] = in_use && overlaps(probe[p], box);
    end
  end

  // token is reset; the flags flush through from the row head on their own
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out.token <= 1'b0;
    end else begin
      link_out.token <= link_in.token;
    end
    link_out.blocked <= link_in.blocked | hit_here;
  end

endmodule

`default_nettype wire

/* hdl/asm_ctrl.sv */
// ----------------------------------------------------------------------------
// asm_ctrl - item control for the AABB slide move block
// Config registers, item capture, probe box set-up, scan sequencing and
// the result register with the slide decision.
// ----------------------------------------------------------------------------
`default_nettype none

module asm_ctrl import asm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]       cfg_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [CMD_BITS-1:0]       command,
  input  logic [INDEX_BITS-1:0]     box_index,
  input  coord_t                    first_x,
  input  coord_t                    first_y,
  input  coord_t                    first_z,
  input  coord_t                    second_x,
  input  coord_t                    second_y,
  input  coord_t                    second_z,
  output logic                      result_valid,
  input  logic                      result_stall,
  output coord_t                    pos_x,
  output coord_t                    pos_y,
  output coord_t                    pos_z,
  output logic                      hit,
  output logic [OUTCOME_BITS-1:0]   outcome,
  output scan_ctl_t                 ctl,
  output bounds_t                   probe [PROBES],
  input  chain_t                    chain_end
);

  state_t                state, state_next;
  logic [DIM_BITS-1:0]   radius;
  logic [DIM_BITS-1:0]   height;
  logic [COUNT_BITS-1:0] box_count;
  logic                  launch;
  logic                  is_move;
  coord_t                cur_x, cur_y, cur_z;
  coord_t                dst_x, dst_y, dst_z;
  logic [PROBES-1:0]     flags;

  logic                  accept;
  logic                  is_query;
  logic                  out_free;
  logic                  take_flags;
  logic                  load_res;
  coord_t                res_x, res_y, res_z;
  logic                  res_hit;
  outcome_t              res_outc;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      radius    <= RADIUS_RESET;
      height    <= HEIGHT_RESET;
      box_count <= COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RADIUS: radius    <= cfg_data;
        REG_HEIGHT: height    <= cfg_data;
        REG_COUNT:  box_count <= cfg_data[COUNT_BITS-1:0];
        default:    ;
      endcase
    end
  end

  assign accept   = item_valid && (state == ST_IDLE);
  assign is_query = (command == CMD_CHECK) || (command == CMD_MOVE);
  assign out_free = !result_valid || !result_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept && is_query) state_next = ST_SCAN;
      ST_SCAN: if (chain_end.token) state_next = ST_WAIT;
      ST_WAIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_stall  = (state != ST_IDLE);
    take_flags  = (state == ST_SCAN) && chain_end.token;
    load_res    = (state == ST_WAIT) && out_free;
    ctl.load_we = accept && (command == CMD_LOAD) &&
                  (32'(box_index) < 32'(MAX_BOXES));
    ctl.launch    = launch;
    ctl.box_count = box_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      launch <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept && is_query;
    end
  end

  // item capture and probe boxes; a check uses the full slot at the first point
  always_ff @(posedge clk) begin
    if (accept && is_query) begin
      is_move <= (command == CMD_MOVE);
      cur_x   <= first_x;
      cur_y   <= first_y;
      cur_z   <= first_z;
      dst_x   <= second_x;
      dst_y   <= second_y;
      dst_z   <= second_z;
      if (command == CMD_CHECK) begin
        probe[PRB_FULL] <= make_bounds(first_x, first_y, first_z, radius, height);
      end else begin
        probe[PRB_FULL] <= make_bounds(second_x, second_y, second_z, radius, height);
      end
      probe[PRB_X]  <= make_bounds(second_x, first_y, first_z, radius, height);
      probe[PRB_XZ] <= make_bounds(second_x, first_y, second_z, radius, height);
      probe[PRB_Z]  <= make_bounds(first_x, first_y, second_z, radius, height);
    end
  end

  always_ff @(posedge clk) begin
    if (take_flags) begin
      flags <= chain_end.blocked;
    end
  end

  // slide decision: full, then x (with z if free), then z, else stay
  always_comb begin
    res_x    = cur_x;
    res_y    = cur_y;
    res_z    = cur_z;
    res_hit  = 1'b0;
    res_outc = OUTC_FULL;
    if (!is_move) begin
      res_hit = flags[PRB_FULL];
    end else begin
      priority if (!flags[PRB_FULL]) begin
        res_x = dst_x;
        res_y = dst_y;
        res_z = dst_z;
      end else if (!flags[PRB_X]) begin
        res_x = dst_x;
        if (!flags[PRB_XZ]) begin
          res_z    = dst_z;
          res_outc = OUTC_XZ;
        end else begin
          res_outc = OUTC_X;
        end
      end else if (!flags[PRB_Z]) begin
        res_z    = dst_z;
        res_outc = OUTC_Z;
      end else begin
        res_outc = OUTC_BLOCKED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) begin
      pos_x   <= res_x;
      pos_y   <= res_y;
      pos_z   <= res_z;
      hit     <= res_hit;
      outcome <= res_outc;
    end
  end

`ifndef SYNTHESIS
  a_token_in_scan: assert property (@(posedge clk) disable iff (rst)
    chain_end.token |-> state == ST_SCAN)
    else $error("scan token left the row outside a scan");

  a_launch_in_scan: assert property (@(posedge clk) disable iff (rst)
    launch |-> state == ST_SCAN)
    else $error("scan launched while not scanning");

  a_result_from_wait: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state) == ST_WAIT)
    else $error("result raised without a finished scan");

  a_hit_only_check: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(hit && (outcome != OUTC_FULL)))
    else $error("hit and move outcome both set");
`endif

endmodule

`default_nettype wire

/* hdl/aabb_slide_move.sv */
// ----------------------------------------------------------------------------
// aabb_slide_move - collide and slide of a player box against collider boxes
// A row of box cells; a scan token walks the row testing four probe boxes
// at once, and the control picks the slide outcome from the four flags.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  item      item_valid / item_stall    command, box_index, first_*, second_*
//  result    result_valid / result_stall pos_x/y/z, hit, outcome
//  config    cfg_we                     cfg_index, cfg_data
//
//  A load gives no result.
//  A check or move launches the scan token, which steps one cell a cycle
//  along the row; then the flags are captured and the result is loaded.
//  One item is in work at a time; item_stall is high from acceptance of a
//  check or move until its result is loaded into the output register.
//  Synchronous reset sets the config registers to their defaults; the box
//  table is undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_slide_move import asm_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]       cfg_data,
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic [CMD_BITS-1:0]       command,
  input  logic [INDEX_BITS-1:0]     box_index,
  input  coord_t                    first_x,
  input  coord_t                    first_y,
  input  coord_t                    first_z,
  input  coord_t                    second_x,
  input  coord_t                    second_y,
  input  coord_t                    second_z,
  output logic                      result_valid,
  input  logic                      result_stall,
  output coord_t                    pos_x,
  output coord_t                    pos_y,
  output coord_t                    pos_z,
  output logic                      hit,
  output logic [OUTCOME_BITS-1:0]   outcome
);

  scan_ctl_t ctl;
  bounds_t   probe [PROBES];
  chain_t    links [MAX_BOXES+1];
  box_t      wr_box;

  assign wr_box = '{min_x: first_x, min_y: first_y, min_z: first_z,
                    max_x: second_x, max_y: second_y, max_z: second_z};

  assign links[0] = '{token: ctl.launch, blocked: '0};

  asm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .command      (command),
    .box_index    (box_index),
    .first_x      (first_x),
    .first_y      (first_y),
    .first_z      (first_z),
    .second_x     (second_x),
    .second_y     (second_y),
    .second_z     (second_z),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .hit          (hit),
    .outcome      (outcome),
    .ctl          (ctl),
    .probe        (probe),
    .chain_end    (links[MAX_BOXES])
  );

  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    logic wr;
    logic in_use;

    // counts above the table size simply enable every cell
    assign wr     = ctl.load_we && (32'(box_index) == 32'(i));
    assign in_use = 32'(ctl.box_count) > 32'(i);

    asm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .wr       (wr),
      .in_use   (in_use),
      .wr_box   (wr_box),
      .probe    (probe),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

endmodule

`default_nettype wire
